>>> rtl/core/windowed_majority_consensus_defines.svh
// ----------------------------------------------------------------------------
// windowed majority consensus assertion macros
// shared wrappers for clocked concurrent checks
// ----------------------------------------------------------------------------
`ifndef WINDOWED_MAJORITY_CONSENSUS_DEFINES_SVH
`define WINDOWED_MAJORITY_CONSENSUS_DEFINES_SVH

// same-cycle implication, checked outside reset
`define WMC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define WMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/wmc_pkg.sv
// ----------------------------------------------------------------------------
// wmc_pkg
// shared widths, codes and controller/datapath structs
// ----------------------------------------------------------------------------
package wmc_pkg;

    localparam int POS_W  = 40;
    localparam int BASE_W = 3;
    localparam int CFG_W  = 13;

    localparam logic [BASE_W-1:0] NO_VOTES  = 3'd5;
    localparam logic [CFG_W-1:0]  CAP_RESET = 13'd4096;
    localparam int                VOTE_N    = 5;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic write_base;
        logic drop_all;
        logic evict;
        logic commit;
        logic drop_read;
        logic q_issue;
        logic load_out;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic is_query;
        logic eor;
        logic too_long;
        logic cur_ge_cap;
        logic fit_needed;
        logic table_full;
        logic q_more;
        logic q_done;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/core/wmc_in_if.sv
// ----------------------------------------------------------------------------
// wmc_in_if
// request channel: append base or consensus query
// ----------------------------------------------------------------------------
interface wmc_in_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [wmc_pkg::BASE_W-1:0]     base_code;
    logic                           end_of_read;
    logic [wmc_pkg::POS_W-1:0]      read_start;
    logic [wmc_pkg::POS_W-1:0]      query_position;

    modport source (output valid, operation, base_code, end_of_read, read_start,
                    query_position, input ready);
    modport sink   (input valid, operation, base_code, end_of_read, read_start,
                    query_position, output ready);
endinterface

>>> rtl/core/wmc_out_if.sv
// ----------------------------------------------------------------------------
// wmc_out_if
// result channel: consensus base and status
// ----------------------------------------------------------------------------
interface wmc_out_if;
    logic                           valid;
    logic                           ready;
    logic [wmc_pkg::BASE_W-1:0]     consensus_base;
    logic                           status;

    modport source (output valid, consensus_base, status, input ready);
    modport sink   (input valid, consensus_base, status, output ready);
endinterface

>>> rtl/core/wmc_ram.sv
// ----------------------------------------------------------------------------
// wmc_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module wmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/wmc_ctrl.sv
// ----------------------------------------------------------------------------
// wmc_ctrl
// sequencer for append, eviction, commit and query scan
// ----------------------------------------------------------------------------
module wmc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  wmc_pkg::t_stat i_stat,
    output wmc_pkg::t_cmd  o_cmd
);
    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_APPEND   = 8'b0000_0010,
        S_FIT      = 8'b0000_0100,
        S_FIT_EV   = 8'b0000_1000,
        S_CLOSE    = 8'b0001_0000,
        S_CLOSE_EV = 8'b0010_0000,
        S_QRUN     = 8'b0100_0000,
        S_FINISH   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_APPEND;
                end
            end
            S_APPEND: begin
                if (i_stat.is_query) begin
                    n_state = S_QRUN;
                end else begin
                    if (!i_stat.too_long) begin
                        if (i_stat.cur_ge_cap) begin
                            o_cmd.drop_all = 1'b1;
                        end else begin
                            o_cmd.write_base = 1'b1;
                        end
                    end
                    n_state = S_FIT;
                end
            end
            S_FIT: begin
                if (i_stat.fit_needed) begin
                    n_state = S_FIT_EV;
                end else if (i_stat.eor) begin
                    n_state = S_CLOSE;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FIT_EV: begin
                o_cmd.evict = 1'b1;
                n_state     = S_FIT;
            end
            S_CLOSE: begin
                if (i_stat.too_long) begin
                    o_cmd.drop_read = 1'b1;
                    n_state         = S_FINISH;
                end else if (i_stat.table_full) begin
                    n_state = S_CLOSE_EV;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_FINISH;
                end
            end
            S_CLOSE_EV: begin
                o_cmd.evict = 1'b1;
                n_state     = S_CLOSE;
            end
            S_QRUN: begin
                o_cmd.q_issue = i_stat.q_more;
                if (i_stat.q_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

>>> rtl/core/wmc_dp.sv
// ----------------------------------------------------------------------------
// wmc_dp
// window state, read table, base store, vote pipeline, result register
// ----------------------------------------------------------------------------
module wmc_dp #(
    parameter int DEPTH = 8192,
    parameter int SLOTS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [wmc_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                         i_operation,
    input  logic [wmc_pkg::BASE_W-1:0]   i_base_code,
    input  logic                         i_end_of_read,
    input  logic [wmc_pkg::POS_W-1:0]    i_read_start,
    input  logic [wmc_pkg::POS_W-1:0]    i_query_position,
    input  wmc_pkg::t_cmd                i_cmd,
    output wmc_pkg::t_stat               o_stat,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [wmc_pkg::BASE_W-1:0]   o_consensus_base,
    output logic                         o_status
);
    localparam int AW  = $clog2(DEPTH);
    localparam int LW  = $clog2(DEPTH + 1);
    localparam int SAW = $clog2(SLOTS);
    localparam int CW  = $clog2(SLOTS + 1);
    localparam int EW  = ((LW > wmc_pkg::CFG_W) ? LW : wmc_pkg::CFG_W) + 1;
    localparam int PW  = wmc_pkg::POS_W;
    localparam int BW  = wmc_pkg::BASE_W;
    localparam int TW  = PW + AW + LW;

    // control state
    logic [wmc_pkg::CFG_W-1:0] r_cap;
    logic [SAW-1:0]            r_oldest;
    logic [CW-1:0]             r_count;
    logic [LW-1:0]             r_total;
    logic [AW-1:0]             r_wp;
    logic [LW-1:0]             r_cur;
    logic                      r_too_long;
    logic [CW-1:0]             r_k;
    logic                      r_tab_v;
    logic                      r_h2;
    logic                      r_h3;
    logic                      r_out_valid;

    // payload
    logic                      r_op;
    logic [BW-1:0]             r_base;
    logic                      r_eor;
    logic [PW-1:0]             r_start;
    logic [PW-1:0]             r_qpos;
    logic                      r_status;
    logic [SAW-1:0]            r_qslot;
    logic [AW-1:0]             r_off2;
    logic [AW-1:0]             r_dist2;
    logic [CW-1:0]             r_votes [wmc_pkg::VOTE_N];
    logic [BW-1:0]             r_out_base;
    logic                      r_out_status;

    logic [EW-1:0]  eff_cap;
    logic [EW-1:0]  cur_e;
    logic [EW-1:0]  tot_e;
    logic [SAW:0]   slot_sum;
    logic [SAW-1:0] slot_end;
    logic [SAW-1:0] oldest_inc;
    logic [SAW-1:0] qslot_inc;
    logic [AW-1:0]  wp_inc;
    logic [AW:0]    wp_x;
    logic [AW:0]    cur_x;
    logic [AW-1:0]  commit_off;
    logic [SAW-1:0] tab_raddr;
    logic [TW-1:0]  tab_wdata;
    logic [TW-1:0]  tab_rdata;
    logic [PW-1:0]  t_start;
    logic [AW-1:0]  t_off;
    logic [LW-1:0]  t_len;
    logic [PW-1:0]  diff;
    logic           hit1;
    logic [AW:0]    asum;
    logic [AW-1:0]  baddr;
    logic [BW-1:0]  b_rd;
    logic [BW-1:0]  best;
    logic [CW-1:0]  best_cnt;

    assign cur_e   = EW'(r_cur);
    assign tot_e   = EW'(r_total);
    assign eff_cap = (EW'(r_cap) < EW'(DEPTH)) ? EW'(r_cap) : EW'(DEPTH);

    // ring index arithmetic
    assign slot_sum   = (SAW+1)'(r_oldest) + (SAW+1)'(r_count);
    assign slot_end   = (slot_sum >= (SAW+1)'(SLOTS)) ? SAW'(slot_sum - (SAW+1)'(SLOTS))
                                                      : SAW'(slot_sum);
    assign oldest_inc = (r_oldest == SAW'(SLOTS - 1)) ? '0 : r_oldest + 1'b1;
    assign qslot_inc  = (r_qslot == SAW'(SLOTS - 1)) ? '0 : r_qslot + 1'b1;
    assign wp_inc     = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;

    assign wp_x       = (AW+1)'(r_wp);
    assign cur_x      = (AW+1)'(r_cur);
    assign commit_off = (wp_x >= cur_x) ? AW'(wp_x - cur_x)
                                        : AW'(wp_x + (AW+1)'(DEPTH) - cur_x);

    assign tab_raddr = i_cmd.q_issue ? r_qslot : r_oldest;
    assign tab_wdata = {r_start, commit_off, r_cur};
    assign {t_start, t_off, t_len} = tab_rdata;

    wmc_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (slot_end),
        .i_wdata (tab_wdata),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rdata)
    );

    // query stage 1: coverage check on table entry
    assign diff = r_qpos - t_start;
    assign hit1 = r_tab_v && (r_qpos >= t_start) && (diff < PW'(t_len));

    // query stage 2: base address in the ring
    assign asum  = (AW+1)'(r_off2) + (AW+1)'(r_dist2);
    assign baddr = (asum >= (AW+1)'(DEPTH)) ? AW'(asum - (AW+1)'(DEPTH)) : AW'(asum);

    wmc_ram #(.WIDTH(BW), .DEPTH(DEPTH)) u_bases (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write_base),
        .i_waddr (r_wp),
        .i_wdata (r_base),
        .i_raddr (baddr),
        .o_rdata (b_rd)
    );

    // majority pick, lowest code wins ties
    always_comb begin
        best     = wmc_pkg::NO_VOTES;
        best_cnt = '0;
        for (int i = 0; i < wmc_pkg::VOTE_N; i++) begin
            if (r_votes[i] > best_cnt) begin
                best_cnt = r_votes[i];
                best     = BW'(i);
            end
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.is_query   = (r_op == wmc_pkg::OP_QUERY);
        o_stat.eor        = r_eor;
        o_stat.too_long   = r_too_long;
        o_stat.cur_ge_cap = (cur_e >= eff_cap);
        o_stat.fit_needed = (r_count != '0) && ((tot_e + cur_e) > eff_cap);
        o_stat.table_full = (r_count == CW'(SLOTS));
        o_stat.q_more     = (r_k != r_count);
        o_stat.q_done     = (r_k == r_count) && !(r_tab_v || r_h2 || r_h3);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= wmc_pkg::CAP_RESET;
            r_oldest    <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_wp        <= '0;
            r_cur       <= '0;
            r_too_long  <= 1'b0;
            r_k         <= '0;
            r_tab_v     <= 1'b0;
            r_h2        <= 1'b0;
            r_h3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.write_base) begin
                r_wp  <= wp_inc;
                r_cur <= r_cur + 1'b1;
            end
            if (i_cmd.drop_all) begin
                r_too_long <= 1'b1;
                r_cur      <= '0;
                r_oldest   <= slot_end;
                r_count    <= '0;
                r_total    <= '0;
            end
            if (i_cmd.evict) begin
                r_total  <= r_total - t_len;
                r_oldest <= oldest_inc;
                r_count  <= r_count - 1'b1;
            end
            if (i_cmd.commit) begin
                r_total    <= r_total + r_cur;
                r_count    <= r_count + 1'b1;
                r_cur      <= '0;
                r_too_long <= 1'b0;
            end
            if (i_cmd.drop_read) begin
                r_cur      <= '0;
                r_too_long <= 1'b0;
            end
            if (i_cmd.accept) begin
                r_k <= '0;
            end else if (i_cmd.q_issue) begin
                r_k <= r_k + 1'b1;
            end
            r_tab_v <= i_cmd.q_issue;
            r_h2    <= hit1;
            r_h3    <= r_h2;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= i_operation;
            r_base   <= i_base_code;
            r_eor    <= i_end_of_read;
            r_start  <= i_read_start;
            r_qpos   <= i_query_position;
            r_status <= 1'b0;
            r_qslot  <= r_oldest;
            for (int i = 0; i < wmc_pkg::VOTE_N; i++) begin
                r_votes[i] <= '0;
            end
        end else begin
            if (i_cmd.q_issue) begin
                r_qslot <= qslot_inc;
            end
            if (i_cmd.drop_read) begin
                r_status <= 1'b1;
            end
            // gap and codes above n never vote
            if (r_h3 && (b_rd < wmc_pkg::NO_VOTES)) begin
                r_votes[b_rd] <= r_votes[b_rd] + 1'b1;
            end
        end
        r_off2  <= t_off;
        r_dist2 <= diff[AW-1:0];
        if (i_cmd.load_out) begin
            r_out_base   <= (r_op == wmc_pkg::OP_QUERY) ? best : wmc_pkg::NO_VOTES;
            r_out_status <= r_status;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_consensus_base = r_out_base;
    assign o_status         = r_out_status;
endmodule

>>> rtl/core/windowed_majority_consensus.sv
// ----------------------------------------------------------------------------
// windowed majority consensus
// sliding window of aligned reads with per-position majority vote
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  i_in      in    valid/ready    operation, base_code, end_of_read,
//                                 read_start, query_position
//  o_out     out   valid/ready    consensus_base, status
//  cfg       in    i_cfg_we       i_cfg_wdata (buffer capacity)
//
//  steps: an append request goes through append and fit, plus an evict step per
//  evicted read and a close step when it closes a read; a query runs the read
//  table scan at one entry per cycle
//  reset: synchronous, active low; no memory clearing pass is needed
//  stalls: the result register holds one answer while the next request is
//  taken; a request completes only once that register is free
// ----------------------------------------------------------------------------
`include "windowed_majority_consensus_defines.svh"

module windowed_majority_consensus #(
    parameter int BASE_STORE_DEPTH = 8192,
    parameter int READ_SLOTS       = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [wmc_pkg::CFG_W-1:0]    i_cfg_wdata,
    wmc_in_if.sink                       i_in,
    wmc_out_if.source                    o_out
);
    wmc_pkg::t_cmd  cmd;
    wmc_pkg::t_stat stat;

    // sequencer: one request at a time through append/evict/commit or scan
    wmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // window state, read table ram, base ring ram and vote pipeline
    wmc_dp #(
        .DEPTH (BASE_STORE_DEPTH),
        .SLOTS (READ_SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_operation      (i_in.operation),
        .i_base_code      (i_in.base_code),
        .i_end_of_read    (i_in.end_of_read),
        .i_read_start     (i_in.read_start),
        .i_query_position (i_in.query_position),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_out_valid      (o_out.valid),
        .i_out_ready      (o_out.ready),
        .o_consensus_base (o_out.consensus_base),
        .o_status         (o_out.status)
    );

    // a read is never committed while flagged too long
    `WMC_ASSERT_SAME(a_commit_ok, cmd.commit, !stat.too_long, "commit of dropped read")
    // full table is always drained by one before a commit
    `WMC_ASSERT_SAME(a_commit_room, cmd.commit, !stat.table_full, "commit into full table")
    // an accepted request keeps the input closed next cycle
    `WMC_ASSERT_NEXT(a_one_item, i_in.valid && i_in.ready, !i_in.ready, "second request taken")
endmodule
